@@ sv/jsu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_pkg: shared definitions for the JSON string unescaper
// Widths, character codes, result codes and the result item layout.
// ----------------------------------------------------------------------------
package jsu_pkg;

   localparam int LENGTH_BITS   = 16;
   localparam int SCRATCH_BITS  = 17;
   localparam int BYTE_BITS     = 8;
   localparam int CAPACITY_BITS = 16;
   localparam int FIELD_BITS    = 16;
   localparam int SUM_BITS      =
      ((SCRATCH_BITS > LENGTH_BITS) ? SCRATCH_BITS : LENGTH_BITS) + 2;
   localparam int MAX_RESULTS   = 3;
   localparam int COUNT_BITS    = 2;
   localparam int INDEX_BITS    = 2;
   localparam int CP_BITS       = 16;

   localparam logic [CAPACITY_BITS-1:0] CAPACITY_RESET = 16'd4096;
   localparam logic [FIELD_BITS-1:0]    FIELD_MAX      = 16'hFFFF;

   localparam logic [BYTE_BITS-1:0] CHAR_NUL       = 8'h00;
   localparam logic [BYTE_BITS-1:0] CHAR_QUOTE     = 8'h22;
   localparam logic [BYTE_BITS-1:0] CHAR_SLASH     = 8'h2F;
   localparam logic [BYTE_BITS-1:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [BYTE_BITS-1:0] CHAR_LOWER_B   = 8'h62;
   localparam logic [BYTE_BITS-1:0] CHAR_LOWER_F   = 8'h66;
   localparam logic [BYTE_BITS-1:0] CHAR_LOWER_N   = 8'h6E;
   localparam logic [BYTE_BITS-1:0] CHAR_LOWER_R   = 8'h72;
   localparam logic [BYTE_BITS-1:0] CHAR_LOWER_T   = 8'h74;
   localparam logic [BYTE_BITS-1:0] CHAR_LOWER_U   = 8'h75;
   localparam logic [BYTE_BITS-1:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [BYTE_BITS-1:0] CHAR_FORMFEED  = 8'h0C;
   localparam logic [BYTE_BITS-1:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [BYTE_BITS-1:0] CHAR_RETURN    = 8'h0D;
   localparam logic [BYTE_BITS-1:0] CHAR_TAB       = 8'h09;

   localparam logic [BYTE_BITS-1:0] UTF8_LEAD2 = 8'hC0;
   localparam logic [BYTE_BITS-1:0] UTF8_LEAD3 = 8'hE0;
   localparam logic [BYTE_BITS-1:0] UTF8_CONT  = 8'h80;
   localparam logic [CP_BITS-1:0]   CP_ONE_BYTE_LIMIT = 16'h0080;
   localparam logic [CP_BITS-1:0]   CP_TWO_BYTE_LIMIT = 16'h0800;

   typedef enum logic [1:0] {
      MODE_PLAIN  = 2'd0,
      MODE_ESCAPE = 2'd1,
      MODE_HEX    = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      STATUS_IN_PLACE   = 3'd0,
      STATUS_DECODED    = 3'd1,
      STATUS_BAD_ESCAPE = 3'd2,
      STATUS_BAD_HEX    = 3'd3,
      STATUS_OVERFLOW   = 3'd4,
      STATUS_TEXT_ENDED = 3'd5
   } status_type;

   typedef struct packed {
      logic                  kind;
      logic [BYTE_BITS-1:0]  out_byte;
      status_type            status;
      logic [FIELD_BITS-1:0] string_length;
      logic [FIELD_BITS-1:0] scratch_offset;
      logic                  last;
   } result_item_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0]                  count;
      result_item_type [MAX_RESULTS-1:0]      items;
   } decode_result_type;

endpackage
`default_nettype wire

@@ sv/jsu_req_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_req_if: raw text byte channel
// Valid/ready channel carrying one string body byte and a restart flag.
// ----------------------------------------------------------------------------
interface jsu_req_if;
   import jsu_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] text_byte;
   logic                 restart;

   modport source (output valid, output text_byte, output restart, input ready);
   modport sink   (input valid, input text_byte, input restart, output ready);

endinterface
`default_nettype wire

@@ sv/jsu_rsp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_rsp_if: decoded result channel
// Valid/ready channel carrying one decoded byte or one end-of-string status.
// ----------------------------------------------------------------------------
interface jsu_rsp_if;
   import jsu_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  kind;
   logic [BYTE_BITS-1:0]  out_byte;
   status_type            status;
   logic [FIELD_BITS-1:0] string_length;
   logic [FIELD_BITS-1:0] scratch_offset;
   logic                  last;

   modport source (output valid, output kind, output out_byte, output status,
                   output string_length, output scratch_offset, output last,
                   input ready);
   modport sink   (input valid, input kind, input out_byte, input status,
                   input string_length, input scratch_offset, input last,
                   output ready);

endinterface
`default_nettype wire

@@ sv/jsu_decode.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_decode: escape decoder and string state
// Holds the per-string and per-document state and turns one registered text
// byte into up to three result items in a single pass.
// ----------------------------------------------------------------------------
module jsu_decode (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 fire,
   input  wire logic [jsu_pkg::BYTE_BITS-1:0]        text_byte,
   input  wire logic                                 restart,
   input  wire logic [jsu_pkg::CAPACITY_BITS-1:0]    capacity,
   output      jsu_pkg::decode_result_type           result
);
   import jsu_pkg::*;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_EMIT,
      ACT_HEX_START,
      ACT_HEX_DIGIT,
      ACT_OPEN_ESCAPE,
      ACT_CLOSE,
      ACT_ERROR
   } action_type;

   mode_type                mode_ff, mode_in;
   logic [1:0]              hex_cnt_ff, hex_cnt_in;
   logic [CP_BITS-1:0]      code_point_ff, code_point_in;
   logic [LENGTH_BITS-1:0]  length_ff, length_in;
   logic                    escape_seen_ff, escape_seen_in;
   logic [SCRATCH_BITS-1:0] scratch_used_ff, scratch_used_in;
   logic                    failed_ff, failed_in;

   mode_type                eff_mode;
   logic [1:0]              eff_hex_cnt;
   logic [CP_BITS-1:0]      eff_cp;
   logic [LENGTH_BITS-1:0]  eff_len;
   logic                    eff_esc;
   logic [SCRATCH_BITS-1:0] eff_used;
   logic                    eff_failed;

   logic                    desig_ok;
   logic                    desig_is_u;
   logic [BYTE_BITS-1:0]    desig_byte;
   logic                    hex_ok;
   logic [3:0]              hex_val;
   logic [CP_BITS-1:0]      cp_new;
   logic [COUNT_BITS-1:0]   utf_n;
   logic [BYTE_BITS-1:0]    utf_b0, utf_b1, utf_b2;

   action_type              act_raw, act;
   status_type              err_raw, err;
   logic [COUNT_BITS-1:0]   emit_n;
   logic [BYTE_BITS-1:0]    emit_b0, emit_b1, emit_b2;
   logic                    chk_esc;

   logic [LENGTH_BITS:0]    len_sum;
   logic [SUM_BITS-1:0]     scratch_sum;
   logic [SUM_BITS-1:0]     close_sum;
   logic [SUM_BITS-1:0]     len_ext;
   logic                    room;
   logic [FIELD_BITS-1:0]   len_out;

   assign eff_mode    = restart ? MODE_PLAIN : mode_ff;
   assign eff_hex_cnt = restart ? 2'd0 : hex_cnt_ff;
   assign eff_cp      = restart ? '0 : code_point_ff;
   assign eff_len     = restart ? '0 : length_ff;
   assign eff_esc     = restart ? 1'b0 : escape_seen_ff;
   assign eff_used    = restart ? '0 : scratch_used_ff;
   assign eff_failed  = restart ? 1'b0 : failed_ff;

   always_comb begin
      desig_ok   = 1'b1;
      desig_is_u = 1'b0;
      desig_byte = text_byte;
      unique case (text_byte) inside
         CHAR_QUOTE, CHAR_BACKSLASH, CHAR_SLASH: desig_byte = text_byte;
         CHAR_LOWER_B: desig_byte = CHAR_BACKSPACE;
         CHAR_LOWER_F: desig_byte = CHAR_FORMFEED;
         CHAR_LOWER_N: desig_byte = CHAR_NEWLINE;
         CHAR_LOWER_R: desig_byte = CHAR_RETURN;
         CHAR_LOWER_T: desig_byte = CHAR_TAB;
         CHAR_LOWER_U: desig_is_u = 1'b1;
         default:      desig_ok   = 1'b0;
      endcase
   end

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      case (text_byte) inside
         [8'h30:8'h39]: hex_val = 4'(text_byte - 8'h30);
         [8'h61:8'h66]: hex_val = 4'(text_byte - 8'h57);
         [8'h41:8'h46]: hex_val = 4'(text_byte - 8'h37);
         default:       hex_ok  = 1'b0;
      endcase
   end

   assign cp_new = {eff_cp[CP_BITS-5:0], hex_val};

   always_comb begin
      if (cp_new < CP_ONE_BYTE_LIMIT) begin
         utf_n  = 2'd1;
         utf_b0 = cp_new[7:0];
         utf_b1 = '0;
         utf_b2 = '0;
      end else if (cp_new < CP_TWO_BYTE_LIMIT) begin
         utf_n  = 2'd2;
         utf_b0 = UTF8_LEAD2 | {3'b000, cp_new[10:6]};
         utf_b1 = UTF8_CONT | {2'b00, cp_new[5:0]};
         utf_b2 = '0;
      end else begin
         utf_n  = 2'd3;
         utf_b0 = UTF8_LEAD3 | {4'b0000, cp_new[15:12]};
         utf_b1 = UTF8_CONT | {2'b00, cp_new[11:6]};
         utf_b2 = UTF8_CONT | {2'b00, cp_new[5:0]};
      end
   end

   always_comb begin
      act_raw = ACT_NONE;
      err_raw = STATUS_IN_PLACE;
      emit_n  = 2'd0;
      emit_b0 = text_byte;
      emit_b1 = '0;
      emit_b2 = '0;
      chk_esc = eff_esc;
      if (!eff_failed) begin
         unique case (eff_mode)
            MODE_ESCAPE: begin
               if (desig_is_u) begin
                  act_raw = ACT_HEX_START;
               end else if (desig_ok) begin
                  act_raw = ACT_EMIT;
                  emit_n  = 2'd1;
                  emit_b0 = desig_byte;
               end else begin
                  act_raw = ACT_ERROR;
                  err_raw = STATUS_BAD_ESCAPE;
               end
            end
            MODE_HEX: begin
               if (!hex_ok) begin
                  act_raw = ACT_ERROR;
                  err_raw = STATUS_BAD_HEX;
               end else if (eff_hex_cnt != 2'd3) begin
                  act_raw = ACT_HEX_DIGIT;
               end else begin
                  act_raw = ACT_EMIT;
                  emit_n  = utf_n;
                  emit_b0 = utf_b0;
                  emit_b1 = utf_b1;
                  emit_b2 = utf_b2;
               end
            end
            default: begin
               if (text_byte == CHAR_QUOTE) begin
                  act_raw = ACT_CLOSE;
               end else if (text_byte == CHAR_NUL) begin
                  act_raw = ACT_ERROR;
                  err_raw = STATUS_TEXT_ENDED;
               end else if (text_byte == CHAR_BACKSLASH) begin
                  act_raw = ACT_OPEN_ESCAPE;
                  chk_esc = 1'b1;
               end else begin
                  act_raw = ACT_EMIT;
                  emit_n  = 2'd1;
               end
            end
         endcase
      end
   end

   assign len_sum     = {1'b0, eff_len} + (LENGTH_BITS+1)'(emit_n);
   assign scratch_sum = SUM_BITS'(eff_used) + SUM_BITS'(eff_len) + SUM_BITS'(emit_n);
   assign close_sum   = SUM_BITS'(eff_used) + SUM_BITS'(eff_len) + SUM_BITS'(1);
   assign len_ext     = SUM_BITS'(eff_len);
   assign room        = !len_sum[LENGTH_BITS] &&
                        (!chk_esc || (scratch_sum <= SUM_BITS'(capacity)));
   assign len_out     = (len_ext > SUM_BITS'(FIELD_MAX)) ? FIELD_MAX
                                                         : len_ext[FIELD_BITS-1:0];

   always_comb begin
      act = act_raw;
      err = err_raw;
      if ((act_raw == ACT_EMIT || act_raw == ACT_OPEN_ESCAPE) && !room) begin
         act = ACT_ERROR;
         err = STATUS_OVERFLOW;
      end
   end

   // Next escape mode.
   always_comb begin
      mode_in = mode_ff;
      if (fire) begin
         unique case (act) inside
            ACT_HEX_START, ACT_HEX_DIGIT: mode_in = MODE_HEX;
            ACT_OPEN_ESCAPE:              mode_in = MODE_ESCAPE;
            ACT_EMIT, ACT_CLOSE, ACT_ERROR: mode_in = MODE_PLAIN;
            default:                      mode_in = eff_mode;
         endcase
      end
   end

   // Counters, accumulators and result items.
   always_comb begin
      hex_cnt_in      = hex_cnt_ff;
      code_point_in   = code_point_ff;
      length_in       = length_ff;
      escape_seen_in  = escape_seen_ff;
      scratch_used_in = scratch_used_ff;
      failed_in       = failed_ff;
      result          = '0;
      if (fire) begin
         hex_cnt_in      = eff_hex_cnt;
         code_point_in   = eff_cp;
         length_in       = eff_len;
         escape_seen_in  = eff_esc;
         scratch_used_in = eff_used;
         failed_in       = eff_failed;
      end
      unique case (act)
         ACT_EMIT: begin
            hex_cnt_in                = 2'd0;
            length_in                 = len_sum[LENGTH_BITS-1:0];
            result.count              = emit_n;
            result.items[0].out_byte  = emit_b0;
            result.items[1].out_byte  = emit_b1;
            result.items[2].out_byte  = emit_b2;
         end
         ACT_HEX_START: begin
            hex_cnt_in    = 2'd0;
            code_point_in = '0;
         end
         ACT_HEX_DIGIT: begin
            hex_cnt_in    = 2'(eff_hex_cnt + 2'd1);
            code_point_in = cp_new;
         end
         ACT_OPEN_ESCAPE: begin
            escape_seen_in = 1'b1;
         end
         ACT_CLOSE: begin
            hex_cnt_in                    = 2'd0;
            code_point_in                 = '0;
            length_in                     = '0;
            escape_seen_in                = 1'b0;
            result.count                  = 2'd1;
            result.items[0].kind          = 1'b1;
            result.items[0].last          = 1'b1;
            result.items[0].string_length = len_out;
            if (eff_esc) begin
               scratch_used_in                = close_sum[SCRATCH_BITS-1:0];
               result.items[0].status         = STATUS_DECODED;
               result.items[0].scratch_offset = eff_used[FIELD_BITS-1:0];
            end
         end
         ACT_ERROR: begin
            hex_cnt_in             = 2'd0;
            code_point_in          = '0;
            length_in              = '0;
            escape_seen_in         = 1'b0;
            failed_in              = 1'b1;
            result.count           = 2'd1;
            result.items[0].kind   = 1'b1;
            result.items[0].last   = 1'b1;
            result.items[0].status = err;
         end
         default: begin
         end
      endcase
      if (!fire) begin
         hex_cnt_in      = hex_cnt_ff;
         code_point_in   = code_point_ff;
         length_in       = length_ff;
         escape_seen_in  = escape_seen_ff;
         scratch_used_in = scratch_used_ff;
         failed_in       = failed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_PLAIN;
         hex_cnt_ff      <= 2'd0;
         code_point_ff   <= '0;
         length_ff       <= '0;
         escape_seen_ff  <= 1'b0;
         scratch_used_ff <= '0;
         failed_ff       <= 1'b0;
      end else begin
         mode_ff         <= mode_in;
         hex_cnt_ff      <= hex_cnt_in;
         code_point_ff   <= code_point_in;
         length_ff       <= length_in;
         escape_seen_ff  <= escape_seen_in;
         scratch_used_ff <= scratch_used_in;
         failed_ff       <= failed_in;
      end
   end

   a_failed_is_silent: assert property (@(posedge clock) disable iff (reset)
      (fire && failed_ff && !restart) |-> (result.count == 2'd0))
      else $error("failed string produced a result");

   a_multi_is_data: assert property (@(posedge clock) disable iff (reset)
      (result.count > 2'd1) |-> (!result.items[0].kind && !result.items[1].kind))
      else $error("multi-item result carries a status item");

   a_scratch_moves_on_close: assert property (@(posedge clock) disable iff (reset)
      (fire && !restart && (scratch_used_in != scratch_used_ff))
         |-> (result.count == 2'd1 && result.items[0].status == STATUS_DECODED))
      else $error("scratch count changed without a decoded close");

endmodule
`default_nettype wire

@@ sv/jsu_rsp_buf.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_rsp_buf: result register and serializer
// Holds the up to three result items of one text byte and presents them on
// the result channel one per transfer.
// ----------------------------------------------------------------------------
module jsu_rsp_buf (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       load,
   input  wire jsu_pkg::decode_result_type result,
   output      logic                       advance,
   jsu_rsp_if.source                       rsp_chan
);
   import jsu_pkg::*;

   result_item_type [MAX_RESULTS-1:0] items_ff;
   logic [COUNT_BITS-1:0]             cnt_ff, cnt_in;
   logic [INDEX_BITS-1:0]             rd_idx_ff, rd_idx_in;
   result_item_type                   head;
   logic                              pop;

   assign head    = items_ff[rd_idx_ff];
   assign pop     = rsp_chan.valid && rsp_chan.ready;
   assign advance = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_chan.ready);

   assign rsp_chan.valid          = (cnt_ff != 2'd0);
   assign rsp_chan.kind           = head.kind;
   assign rsp_chan.out_byte       = head.out_byte;
   assign rsp_chan.status         = head.status;
   assign rsp_chan.string_length  = head.string_length;
   assign rsp_chan.scratch_offset = head.scratch_offset;
   assign rsp_chan.last           = head.last;

   always_comb begin
      cnt_in    = cnt_ff;
      rd_idx_in = rd_idx_ff;
      if (load) begin
         cnt_in    = result.count;
         rd_idx_in = '0;
      end else if (pop) begin
         cnt_in    = 2'(cnt_ff - 2'd1);
         rd_idx_in = 2'(rd_idx_ff + 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         rd_idx_ff <= '0;
      end else begin
         cnt_ff    <= cnt_in;
         rd_idx_ff <= rd_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         items_ff <= result.items;
      end
   end

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, rd_idx_ff} + {1'b0, cnt_ff}) <= 3'd3)
      else $error("read index runs past the held items");

   a_pop_steps_index: assert property (@(posedge clock) disable iff (reset)
      (pop && !load) |=> (rd_idx_ff == 2'($past(rd_idx_ff) + 2'd1)))
      else $error("transfer did not step the read index");

   a_last_marks_status: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.last == rsp_chan.kind))
      else $error("last flag disagrees with item kind");

endmodule
`default_nettype wire

@@ sv/json_string_unescaper_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_unescaper_core: JSON string body unescaper
// Decodes the body of a JSON string into plain bytes and a closing status.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan takes one raw byte of a string body per transfer, starting
//   after the opening quote; restart set on a byte clears the scratch count
//   and any sticky error before that byte is decoded.
//   rsp_chan gives each decoded byte as a data item (kind 0) and one status
//   item (kind 1, last 1) at the closing quote or on the first error. After
//   an error, bytes are taken and dropped until a restart.
//   A \uXXXX escape yields up to three UTF-8 bytes on its last hex digit.
//   csr_write_enable writes the scratch capacity; write it only while idle.
// Timing:
//   A byte's first result is offered once the byte has passed the input
//   register and been loaded into the result register. One byte is taken
//   every cycle while each byte gives at most one result and the receiver
//   is ready; a byte that gives more results holds the input until the
//   result register has drained its items, one per transfer.
// Reset clears all string and document state and sets the capacity to 4096.
// When the receiver stalls, the result register holds its items and the
// input register fills, after which req_chan.ready drops.
// ----------------------------------------------------------------------------
module json_string_unescaper_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   jsu_req_if.sink                                req_chan,
   jsu_rsp_if.source                              rsp_chan,
   input  wire logic                              csr_write_enable,
   input  wire logic [jsu_pkg::CAPACITY_BITS-1:0] csr_write_data
);
   import jsu_pkg::*;

   logic                     req_valid_ff;
   logic [BYTE_BITS-1:0]     req_byte_ff;
   logic                     req_restart_ff;
   logic [CAPACITY_BITS-1:0] capacity_ff;
   logic                     advance;
   logic                     fire;
   decode_result_type        result;

   assign req_chan.ready = !req_valid_ff || advance;
   assign fire           = req_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         req_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         req_byte_ff    <= req_chan.text_byte;
         req_restart_ff <= req_chan.restart;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_write_enable) begin
         capacity_ff <= csr_write_data;
      end
   end

   jsu_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .text_byte (req_byte_ff),
      .restart   (req_restart_ff),
      .capacity  (capacity_ff),
      .result    (result)
   );

   jsu_rsp_buf u_rsp_buf (
      .clock    (clock),
      .reset    (reset),
      .load     (fire),
      .result   (result),
      .advance  (advance),
      .rsp_chan (rsp_chan)
   );

endmodule
`default_nettype wire
